// ===== rtl/core/breakpoint_envelope_generator_top_defines.svh =====
// Assertion macros for the breakpoint envelope generator.
// Included by the top level; no other dependencies.
`ifndef BREAKPOINT_ENVELOPE_GENERATOR_TOP_DEFINES_SVH
`define BREAKPOINT_ENVELOPE_GENERATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication under reset disable
`define BEG_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("envelope assertion failed");
// Next-cycle implication under reset disable
`define BEG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("envelope assertion failed");
`else
`define BEG_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define BEG_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/core/beg_pkg.sv =====
// Shared types and constants for the breakpoint envelope generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package beg_pkg;

  localparam int MAX_POINTS = 8;
  localparam int PT_IDX_W   = $clog2(MAX_POINTS);
  localparam int PT_CNT_W   = PT_IDX_W + 1;
  localparam int TIME_BITS  = 32;
  localparam int START_W    = 16;
  localparam int VALUE_W    = 16;
  localparam int REL_W      = 16;
  localparam int ABS_W      = 24;
  localparam int SS_W       = START_W + ABS_W;   // scaled start width
  localparam int D_W        = SS_W + 1;          // signed segment/offset width
  localparam int ACC_W      = 64;                // multiply-accumulate width
  localparam int MAG_W      = VALUE_W + 1;       // magnitude of level or level delta
  localparam int CNT_W      = $clog2(ACC_W) + 1;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_KEY_ON = 2'd1,
    OP_LOAD   = 2'd2
  } beg_op_t;

  typedef enum logic [1:0] {
    REG_POINT_COUNT     = 2'd0,
    REG_RELATIVE_LENGTH = 2'd1,
    REG_ABSOLUTE_LENGTH = 2'd2
  } beg_reg_t;

  typedef struct packed {
    logic [1:0]                op;
    logic [PT_IDX_W-1:0]       point_index;
    logic [START_W-1:0]        point_start;
    logic signed [VALUE_W-1:0] point_value;
  } beg_cmd_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sample;
    logic [PT_IDX_W-1:0]       segment;
    logic                      holding;
  } beg_env_t;

  typedef struct packed {
    logic [3:0]       point_count;
    logic [REL_W-1:0] relative_length;
    logic [ABS_W-1:0] absolute_length;
  } beg_cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_point;
    logic key_on;
    logic idx_next;
    logic mul_load;
    logic div_start;
    logic div_interp;
    logic ss_latch;
    logic cs_latch;
    logic seg_inc;
    logic mac_load1;
    logic mac_load2;
    logic mac_step;
    logic res_load;
    logic res_interp;
    logic res_hold;
    logic time_inc;
  } beg_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic running;
    logic seg_last;
    logic ss_hit;
    logic ss_flat;
    logic div_busy;
    logic mac_zero;
    logic out_free;
  } beg_status_t;

endpackage

// ===== rtl/core/beg_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on beg_pkg for widths.
`timescale 1ns / 1ps

module beg_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [beg_pkg::ACC_W-1:0] num,
  input  logic [beg_pkg::SS_W-1:0]  den,
  input  logic [beg_pkg::CNT_W-1:0] steps,
  output logic                      busy,
  output logic [beg_pkg::ACC_W-1:0] quo
);
  import beg_pkg::*;

  logic [SS_W-1:0]  rem;
  logic [SS_W-1:0]  den_q;
  logic [ACC_W-1:0] num_sh;
  logic [CNT_W-1:0] cnt;
  logic [SS_W:0]    rem_sh;
  logic [SS_W:0]    rem_diff;
  logic             ge;

  // Shift in the next numerator bit and trial-subtract
  assign rem_sh   = {rem, num_sh[ACC_W-1]};
  assign rem_diff = rem_sh - {1'b0, den_q};
  assign ge       = (rem_sh >= {1'b0, den_q});

  // Control: step count and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= steps;
    end else if (busy) begin
      cnt  <= cnt - CNT_W'(1);
      busy <= (cnt != CNT_W'(1));
    end
  end

  // Datapath: remainder, shifted numerator, quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= '0;
      num_sh <= num;
      den_q  <= den;
      quo    <= '0;
    end else if (busy) begin
      rem    <= ge ? rem_diff[SS_W-1:0] : rem_sh[SS_W-1:0];
      num_sh <= {num_sh[ACC_W-2:0], 1'b0};
      quo    <= {quo[ACC_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/core/beg_datapath.sv =====
// Datapath: breakpoint tables, envelope state, scaling multiplier,
// shift-add accumulator, output register. Depends on beg_pkg, beg_divider.
`timescale 1ns / 1ps

module beg_datapath (
  input  logic                clk,
  input  logic                rst,
  input  beg_pkg::beg_cfg_t   cfg,
  input  beg_pkg::beg_cmd_t   cmd,
  input  beg_pkg::beg_ctl_t   ctl,
  output beg_pkg::beg_status_t stat,
  output logic                env_valid,
  input  logic                env_stall,
  output beg_pkg::beg_env_t   env
);
  import beg_pkg::*;

  logic [START_W-1:0]        start_tab [MAX_POINTS];
  logic signed [VALUE_W-1:0] value_tab [MAX_POINTS];
  logic [PT_IDX_W-1:0]       seg;
  logic                      running;
  logic [TIME_BITS-1:0]      tick_time;

  logic [SS_W-1:0]           prod;
  logic [SS_W-1:0]           ss_reg;
  logic [SS_W-1:0]           cs_reg;
  logic signed [VALUE_W-1:0] a_reg;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   mac_y;
  logic [MAG_W-1:0]          mac_x;
  logic                      mac_neg;

  logic [PT_IDX_W-1:0]       rd_idx;
  logic [START_W-1:0]        rd_start;
  logic signed [VALUE_W-1:0] rd_value;
  logic [PT_CNT_W-1:0]       count_used;
  logic [PT_CNT_W-1:0]       seg_plus;
  logic signed [D_W-1:0]     seg_len;
  logic signed [D_W-1:0]     offs;
  logic [D_W-1:0]            seg_len_mag;
  logic signed [MAG_W-1:0]   a_ext;
  logic signed [MAG_W-1:0]   diff;
  logic [ACC_W-1:0]          acc_mag;
  logic [REL_W-1:0]          rel_used;
  logic [ACC_W-1:0]          div_num;
  logic [SS_W-1:0]           div_den;
  logic [CNT_W-1:0]          div_steps;
  logic                      div_busy;
  logic [ACC_W-1:0]          quo;
  logic                      q_neg;
  logic signed [VALUE_W-1:0] sat_level;

  // Table read port, one address per cycle
  assign rd_idx   = ctl.idx_next ? PT_IDX_W'(seg + PT_IDX_W'(1)) : seg;
  assign rd_start = start_tab[rd_idx];
  assign rd_value = value_tab[rd_idx];

  // Points in use, clamped to the table
  always_comb begin
    if (cfg.point_count == 4'd0) begin
      count_used = PT_CNT_W'(1);
    end else if (cfg.point_count > 4'(MAX_POINTS)) begin
      count_used = PT_CNT_W'(MAX_POINTS);
    end else begin
      count_used = PT_CNT_W'(cfg.point_count);
    end
  end

  assign seg_plus      = {1'b0, seg} + PT_CNT_W'(1);
  assign stat.seg_last = (seg_plus >= count_used);
  assign stat.running  = running;
  assign stat.ss_hit   = (ss_reg == SS_W'(tick_time));
  assign stat.ss_flat  = (ss_reg == cs_reg);
  assign stat.div_busy = div_busy;
  assign stat.mac_zero = (mac_x == '0);
  assign stat.out_free = !env_valid || !env_stall;

  // Segment length and offset into the segment, in ticks
  assign seg_len     = $signed({1'b0, ss_reg}) - $signed({1'b0, cs_reg});
  assign offs        = $signed(D_W'(tick_time)) - $signed({1'b0, cs_reg});
  assign seg_len_mag = seg_len[D_W-1] ? D_W'(-seg_len) : D_W'(seg_len);
  assign a_ext       = MAG_W'(rd_value);
  assign diff        = MAG_W'(rd_value) - MAG_W'(a_reg);
  assign acc_mag     = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);

  // Divider operands: scaled start or interpolation quotient
  assign rel_used = (cfg.relative_length == '0) ? REL_W'(1) : cfg.relative_length;
  always_comb begin
    if (ctl.div_interp) begin
      div_num   = acc_mag;
      div_den   = seg_len_mag[SS_W-1:0];
      div_steps = CNT_W'(ACC_W);
    end else begin
      div_num   = {prod, {(ACC_W-SS_W){1'b0}}};
      div_den   = SS_W'(rel_used);
      div_steps = CNT_W'(SS_W);
    end
  end

  beg_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.div_start),
    .num   (div_num),
    .den   (div_den),
    .steps (div_steps),
    .busy  (div_busy),
    .quo   (quo)
  );

  // Sign and saturate the interpolated level
  assign q_neg = acc[ACC_W-1] ^ seg_len[D_W-1];
  always_comb begin
    if (!q_neg) begin
      sat_level = (quo > ACC_W'(32767)) ? 16'sh7fff : $signed(quo[VALUE_W-1:0]);
    end else begin
      sat_level = (quo > ACC_W'(32768)) ? 16'sh8000
                                        : $signed(VALUE_W'(~quo[VALUE_W-1:0] + 16'd1));
    end
  end

  // Tables and envelope state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_POINTS; i++) begin
        start_tab[i] <= '0;
        value_tab[i] <= '0;
      end
      seg       <= '0;
      running   <= 1'b0;
      tick_time <= '0;
    end else begin
      if (ctl.load_point) begin
        start_tab[cmd.point_index] <= cmd.point_start;
        value_tab[cmd.point_index] <= cmd.point_value;
        running <= 1'b0;
        seg     <= '0;
      end
      if (ctl.key_on) begin
        running   <= 1'b1;
        seg       <= '0;
        tick_time <= '0;
      end
      if (ctl.seg_inc) begin
        seg <= seg + PT_IDX_W'(1);
      end
      if (ctl.time_inc) begin
        tick_time <= tick_time + TIME_BITS'(1);
      end
    end
  end

  // Scaling product and latched scaled starts
  always_ff @(posedge clk) begin
    if (ctl.mul_load) begin
      prod <= SS_W'(rd_start) * SS_W'(cfg.absolute_length);
    end
    if (ctl.ss_latch) begin
      ss_reg <= quo[SS_W-1:0];
    end
    if (ctl.cs_latch) begin
      cs_reg <= quo[SS_W-1:0];
    end
  end

  // Shift-add accumulate: level times length, plus delta times offset
  always_ff @(posedge clk) begin
    if (rst) begin
      mac_x <= '0;
    end else if (ctl.mac_load1) begin
      mac_x <= a_ext[MAG_W-1] ? MAG_W'(-a_ext) : MAG_W'(a_ext);
    end else if (ctl.mac_load2) begin
      mac_x <= diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    end else if (ctl.mac_step) begin
      mac_x <= mac_x >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mac_load1) begin
      a_reg   <= rd_value;
      acc     <= '0;
      mac_neg <= a_ext[MAG_W-1];
      mac_y   <= ACC_W'(seg_len);
    end else if (ctl.mac_load2) begin
      mac_neg <= diff[MAG_W-1];
      mac_y   <= ACC_W'(offs);
    end else if (ctl.mac_step) begin
      if (mac_x[0]) begin
        acc <= mac_neg ? acc - mac_y : acc + mac_y;
      end
      mac_y <= mac_y <<< 1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      env_valid <= 1'b0;
    end else if (ctl.res_load) begin
      env_valid <= 1'b1;
    end else if (!env_stall) begin
      env_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      env.sample  <= ctl.res_interp ? sat_level : rd_value;
      env.segment <= seg;
      env.holding <= ctl.res_hold;
    end
  end

endmodule

// ===== rtl/core/beg_ctrl.sv =====
// Controller state machine: sequences probes, interpolation and output.
// Depends on beg_pkg for command and status types.
`timescale 1ns / 1ps

module beg_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  input  logic [1:0]           op,
  input  beg_pkg::beg_status_t stat,
  output beg_pkg::beg_ctl_t    ctl,
  output logic                 cmd_stall
);
  import beg_pkg::*;

  typedef enum logic [16:0] {
    ST_IDLE     = 17'h00001,
    ST_P_MUL    = 17'h00002,
    ST_P_DIV    = 17'h00004,
    ST_P_WAIT   = 17'h00008,
    ST_P_CHK    = 17'h00010,
    ST_P_TEST   = 17'h00020,
    ST_C_MUL    = 17'h00040,
    ST_C_DIV    = 17'h00080,
    ST_C_WAIT   = 17'h00100,
    ST_C_CHK    = 17'h00200,
    ST_M1_LD    = 17'h00400,
    ST_M1       = 17'h00800,
    ST_M2       = 17'h01000,
    ST_D_WAIT   = 17'h02000,
    ST_E_HOLD   = 17'h04000,
    ST_E_FLAT   = 17'h08000,
    ST_E_INTERP = 17'h10000
  } beg_state_t;

  beg_state_t state;
  beg_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign cmd_stall = (state != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (beg_op_t'(op))
            OP_KEY_ON: ctl.key_on = 1'b1;
            OP_LOAD:   ctl.load_point = 1'b1;
            OP_TICK: begin
              state_next = (!stat.running || stat.seg_last) ? ST_E_HOLD : ST_P_MUL;
            end
            default: ;
          endcase
        end
      end
      ST_P_MUL: begin
        ctl.idx_next = 1'b1;
        ctl.mul_load = 1'b1;
        state_next   = ST_P_DIV;
      end
      ST_P_DIV: begin
        ctl.div_start = 1'b1;
        state_next    = ST_P_WAIT;
      end
      ST_P_WAIT: begin
        if (!stat.div_busy) begin
          ctl.ss_latch = 1'b1;
          state_next   = ST_P_CHK;
        end
      end
      ST_P_CHK: begin
        if (stat.ss_hit) begin
          ctl.seg_inc = 1'b1;
          state_next  = ST_P_TEST;
        end else begin
          state_next  = ST_C_MUL;
        end
      end
      ST_P_TEST: begin
        state_next = stat.seg_last ? ST_E_HOLD : ST_P_MUL;
      end
      ST_C_MUL: begin
        ctl.mul_load = 1'b1;
        state_next   = ST_C_DIV;
      end
      ST_C_DIV: begin
        ctl.div_start = 1'b1;
        state_next    = ST_C_WAIT;
      end
      ST_C_WAIT: begin
        if (!stat.div_busy) begin
          ctl.cs_latch = 1'b1;
          state_next   = ST_C_CHK;
        end
      end
      ST_C_CHK: begin
        state_next = stat.ss_flat ? ST_E_FLAT : ST_M1_LD;
      end
      ST_M1_LD: begin
        ctl.mac_load1 = 1'b1;
        state_next    = ST_M1;
      end
      ST_M1: begin
        if (stat.mac_zero) begin
          ctl.idx_next  = 1'b1;
          ctl.mac_load2 = 1'b1;
          state_next    = ST_M2;
        end else begin
          ctl.mac_step = 1'b1;
        end
      end
      ST_M2: begin
        if (stat.mac_zero) begin
          ctl.div_start  = 1'b1;
          ctl.div_interp = 1'b1;
          state_next     = ST_D_WAIT;
        end else begin
          ctl.mac_step = 1'b1;
        end
      end
      ST_D_WAIT: begin
        ctl.div_interp = 1'b1;
        if (!stat.div_busy) begin
          state_next = ST_E_INTERP;
        end
      end
      ST_E_HOLD: begin
        if (stat.out_free) begin
          ctl.res_load = 1'b1;
          ctl.res_hold = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_E_FLAT: begin
        if (stat.out_free) begin
          ctl.res_load = 1'b1;
          ctl.time_inc = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_E_INTERP: begin
        ctl.div_interp = 1'b1;
        if (stat.out_free) begin
          ctl.res_load   = 1'b1;
          ctl.res_interp = 1'b1;
          ctl.time_inc   = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/breakpoint_envelope_generator_top.sv =====
// Top level of the breakpoint envelope generator: APB register file,
// controller and datapath. Depends on beg_pkg, beg_ctrl, beg_datapath.
//
//  channel | direction | handshake          | payload
//  cmd     | in        | cmd_valid/cmd_stall | beg_cmd_t (op, index, start, value)
//  env     | out       | env_valid/env_stall | beg_env_t (sample, segment, holding)
//  apb     | in        | psel/penable/pready | 32-bit registers at 0x0, 0x4, 0x8
//
// Key-on, load and unused codes complete in the idle state; idle or holding ticks pass
// through ST_E_HOLD. An interpolating tick computes scaled starts (skipped points plus two in
// all) with the 40-step divider, then runs the shift-add accumulator and the 64-step
// interpolation divide.
// Reset is synchronous and clears the tables and state at once.
// The output register holds a result under env_stall while the next item runs.
`timescale 1ns / 1ps
`include "breakpoint_envelope_generator_top_defines.svh"

module breakpoint_envelope_generator_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_stall,
  input  beg_pkg::beg_cmd_t              cmd,
  output logic                           env_valid,
  input  logic                           env_stall,
  output beg_pkg::beg_env_t              env,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [beg_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [beg_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [beg_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import beg_pkg::*;

  beg_cfg_t    cfg;
  beg_ctl_t    ctl;
  beg_status_t stat;
  beg_reg_t    reg_sel;
  logic        cfg_wr;
  logic        cmd_acc;

  assign pready  = 1'b1;
  assign reg_sel = beg_reg_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cmd_acc = cmd_valid && !cmd_stall;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.point_count     <= 4'd2;
      cfg.relative_length <= REL_W'(256);
      cfg.absolute_length <= ABS_W'(1);
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_POINT_COUNT:     cfg.point_count     <= pwdata[3:0];
        REG_RELATIVE_LENGTH: cfg.relative_length <= pwdata[REL_W-1:0];
        REG_ABSOLUTE_LENGTH: cfg.absolute_length <= pwdata[ABS_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    case (reg_sel)
      REG_POINT_COUNT:     prdata = CFG_DATA_W'(cfg.point_count);
      REG_RELATIVE_LENGTH: prdata = CFG_DATA_W'(cfg.relative_length);
      REG_ABSOLUTE_LENGTH: prdata = CFG_DATA_W'(cfg.absolute_length);
      default:             prdata = '0;
    endcase
  end

  beg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .op        (cmd.op),
    .stat      (stat),
    .ctl       (ctl),
    .cmd_stall (cmd_stall)
  );

  beg_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .ctl       (ctl),
    .stat      (stat),
    .env_valid (env_valid),
    .env_stall (env_stall),
    .env       (env)
  );

  // Tick transactions always leave the block busy once they are taken
  `BEG_ASSERT_NEXT(a_tick_busy, clk, rst, cmd_acc && (cmd.op == OP_TICK), cmd_stall)
  // Key-on and load complete in the cycle they are taken
  `BEG_ASSERT_NEXT(a_ctl_quick, clk, rst, cmd_acc && (cmd.op != OP_TICK) && (cmd.op != 2'd3), !cmd_stall)
  // The divider is quiet whenever the block is idle
  `BEG_ASSERT_NOW(a_idle_div, clk, rst, !cmd_stall, !stat.div_busy)
  // Never overwrite a result still waiting under stall
  `BEG_ASSERT_NOW(a_no_overrun, clk, rst, ctl.res_load, !env_valid || !env_stall)

endmodule

// ===== dv/breakpoint_envelope_generator_top_test.sv =====
// Self-checking testbench for the breakpoint envelope generator top level.
// Depends on beg_pkg and breakpoint_envelope_generator_top; drives cmd, env and APB.
`timescale 1ns / 1ps

module breakpoint_envelope_generator_top_test;
  import beg_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 8000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int NUM_PHASES = 13;
  localparam int PHASE_ITEMS = 128;

  typedef struct packed {
    beg_cmd_t c;
    logic     typed;
    beg_env_t e;
  } stim_row_t;

  // Directed rows; reset config is count 2, relative 256, absolute 1
  localparam int NUM_ROWS = 14;
  localparam stim_row_t DIRECTED[NUM_ROWS] = '{
    '{'{OP_TICK,   3'd0, 16'h0000, 16'h0000}, 1'b1, '{16'h0000, 3'd0, 1'b1}},
    '{'{OP_LOAD,   3'd0, 16'h0000, 16'h8000}, 1'b0, '0},
    '{'{OP_TICK,   3'd0, 16'h0000, 16'h0000}, 1'b1, '{16'h8000, 3'd0, 1'b1}},
    '{'{OP_LOAD,   3'd1, 16'hFFFF, 16'h7FFF}, 1'b0, '0},
    '{'{OP_LOAD,   3'd7, 16'hFFFF, 16'h7FFF}, 1'b0, '0},
    '{'{OP_UNUSED, 3'd5, 16'h1234, 16'h4321}, 1'b0, '0},
    '{'{OP_KEY_ON, 3'd0, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{OP_TICK,   3'd0, 16'h0000, 16'h0000}, 1'b1, '{16'h8000, 3'd0, 1'b0}},
    '{'{OP_TICK,   3'd0, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{OP_TICK,   3'd0, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{OP_LOAD,   3'd1, 16'h0000, 16'd100},  1'b0, '0},
    '{'{OP_KEY_ON, 3'd0, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{OP_TICK,   3'd0, 16'h0000, 16'h0000}, 1'b1, '{16'd100, 3'd1, 1'b1}},
    '{'{OP_TICK,   3'd0, 16'h0000, 16'h0000}, 1'b1, '{16'd100, 3'd1, 1'b1}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  beg_cmd_t cmd = '0;
  logic env_valid;
  logic env_stall = 1'b0;
  beg_env_t env;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  breakpoint_envelope_generator_top i_dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .env_valid(env_valid), .env_stall(env_stall), .env(env),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Envelope state mirror
  logic [15:0] env_start[MAX_POINTS];
  logic [15:0] env_level[MAX_POINTS];
  int unsigned env_seg;
  bit env_running;
  longint unsigned env_ticks;
  int unsigned cfg_count = 2;
  int unsigned cfg_rel = 256;
  int unsigned cfg_abs = 1;

  beg_env_t pending_env[$];
  int errors = 0;
  int items_sent = 0;
  int envs_seen = 0;
  int cycles = 0;
  bit sender_idles = 1'b1;

  function automatic longint unsigned scaled_start(int unsigned idx);
    longint unsigned r;
    r = (cfg_rel == 0) ? 1 : cfg_rel;
    return (longint'(env_start[idx]) * longint'(cfg_abs)) / r;
  endfunction

  function automatic longint level_at(int unsigned idx);
    return longint'($signed(env_level[idx]));
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // a + (b - a) * p / d, truncated toward zero, clamped
  function automatic longint lerp_level(longint a, longint b, longint p, longint d);
    longint diff, whole, rem, base, lim;
    diff = b - a;
    lim = longint'(1) << 18;
    if (d < 0) begin
      d = -d;
      p = -p;
    end
    whole = p / d;
    rem = p % d;
    if (whole > lim) whole = lim;
    if (whole < -lim) whole = -lim;
    base = a + diff * whole;
    if (base > lim) return 32767;
    if (base < -lim) return -32768;
    return clamp16((base * d + diff * rem) / d);
  endfunction

  // Advance the mirror by one command; report the envelope value if any
  task automatic predict_envelope(input beg_cmd_t c, output bit produced,
                                  output beg_env_t r);
    int unsigned n, s;
    longint lvl, cs, ns;
    bit hold;
    produced = 1'b0;
    r = '0;
    if (c.op == OP_KEY_ON) begin
      env_seg = 0;
      env_running = 1'b1;
      env_ticks = 0;
    end else if (c.op == OP_LOAD) begin
      env_start[c.point_index] = c.point_start;
      env_level[c.point_index] = c.point_value;
      env_running = 1'b0;
      env_seg = 0;
    end else if (c.op == OP_TICK) begin
      n = (cfg_count == 0) ? 1 : (cfg_count > MAX_POINTS) ? MAX_POINTS : cfg_count;
      s = env_seg;
      hold = 1'b1;
      if (!env_running) begin
        s = 0;
        lvl = level_at(0);
      end else if (s + 1 >= n) begin
        lvl = level_at(s);
      end else begin
        while (s + 1 < n && env_ticks == scaled_start(s + 1)) s++;
        env_seg = s;
        if (s + 1 >= n) begin
          lvl = level_at(s);
        end else begin
          cs = longint'(scaled_start(s));
          ns = longint'(scaled_start(s + 1));
          hold = 1'b0;
          if (ns == cs) lvl = level_at(s);
          else lvl = lerp_level(level_at(s), level_at(s + 1),
                                longint'(env_ticks) - cs, ns - cs);
          env_ticks = (env_ticks + 1) & 64'hFFFF_FFFF;
        end
      end
      r.sample = lvl[15:0];
      r.segment = s[PT_IDX_W-1:0];
      r.holding = hold;
      produced = 1'b1;
    end
  endtask

  // Offer one transaction, with an occasional gap before it
  task automatic send_cmd(input beg_cmd_t c, input bit typed, input beg_env_t typed_env);
    bit produced;
    beg_env_t predicted;
    if (sender_idles && $urandom_range(99) < 8) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (cmd_stall);
    predict_envelope(c, produced, predicted);
    items_sent++;
    if (produced) pending_env.push_back(typed ? typed_env : predicted);
  endtask

  // Drop valid and wait until every expected envelope value is out
  task automatic drain_envelopes();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending_env.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input beg_reg_t idx, input int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(4 * int'(idx));
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_POINT_COUNT:     cfg_count = value & 32'hF;
      REG_RELATIVE_LENGTH: cfg_rel = value & 32'hFFFF;
      REG_ABSOLUTE_LENGTH: cfg_abs = value & 32'hFF_FFFF;
      default: ;
    endcase
  endtask

  function automatic beg_cmd_t tick_cmd();
    beg_cmd_t c;
    c = '0;
    c.op = OP_TICK;
    return c;
  endfunction

  function automatic beg_cmd_t random_cmd();
    beg_cmd_t c;
    c.op = 2'($urandom_range(3));
    c.point_index = PT_IDX_W'($urandom_range(MAX_POINTS - 1));
    c.point_start = 16'($urandom);
    c.point_value = 16'($urandom);
    return c;
  endfunction

  // Pick a setting; first phases take the extremes
  task automatic configure_phase(input int ph);
    int unsigned n, rl, al;
    case (ph)
      0: begin n = 8; rl = 1; al = 24'hFF_FFFF; end
      1: begin n = 1; rl = 65535; al = 1; end
      2: begin n = 0; rl = 0; al = 3; end
      3: begin n = 15; rl = 256; al = 40; end
      default: begin
        n = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(2, 8);
        case ($urandom_range(7))
          0: rl = $urandom_range(1, 65535);
          1: rl = $urandom_range(0, 2);
          default: rl = 256;
        endcase
        al = ($urandom_range(9) == 0) ? $urandom_range(1, 24'hFF_FFFF)
                                      : $urandom_range(1, 48);
      end
    endcase
    write_register(REG_POINT_COUNT, n);
    write_register(REG_RELATIVE_LENGTH, rl);
    write_register(REG_ABSOLUTE_LENGTH, al);
  endtask

  // Load a pattern (in most runs), key on, then run a stretch of ticks with some noise
  task automatic run_sequence();
    logic [15:0] starts[MAX_POINTS];
    int unsigned span, nticks;
    beg_cmd_t c;
    if ($urandom_range(2) != 0) begin
      span = (cfg_rel < 2) ? 16 : cfg_rel;
      foreach (starts[i]) starts[i] = 16'($urandom_range(0, span));
      if ($urandom_range(4) != 0) starts.sort();
      starts[0] = ($urandom_range(3) == 0) ? starts[0] : 16'd0;
      for (int i = 0; i < MAX_POINTS; i++) begin
        c.op = OP_LOAD;
        c.point_index = PT_IDX_W'(i);
        c.point_start = starts[i];
        c.point_value = 16'($urandom);
        send_cmd(c, 1'b0, '0);
      end
    end
    c = '0;
    c.op = OP_KEY_ON;
    send_cmd(c, 1'b0, '0);
    nticks = $urandom_range(1, 60);
    for (int t = 0; t < nticks; t++) begin
      if ($urandom_range(99) < 6) send_cmd(random_cmd(), 1'b0, '0);
      else send_cmd(tick_cmd(), 1'b0, '0);
    end
  endtask

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("breakpoint_envelope_generator_top verification failed");
      $finish;
    end
  end

  // Stall the output at random, with one long hold-off and one quiet window
  initial begin
    int hold_left;
    bit held_once;
    hold_left = 0;
    held_once = 1'b0;
    forever begin
      @(posedge clk);
      if (!held_once && envs_seen == 200) begin
        held_once = 1'b1;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        env_stall <= 1'b1;
      end else if (envs_seen >= 600 && envs_seen < 900) begin
        env_stall <= 1'b0;
      end else begin
        env_stall <= ($urandom_range(99) < 8);
      end
    end
  end

  // Compare each accepted envelope value with the oldest prediction
  always @(posedge clk) begin
    beg_env_t want;
    if (!rst && env_valid && !env_stall) begin
      envs_seen++;
      if (pending_env.size() == 0) begin
        errors++;
        $display("%0t: unexpected envelope value %h", $time, env);
      end else begin
        want = pending_env.pop_front();
        if (env.sample !== want.sample) begin
          errors++;
          $display("%0t: sample expected %0d got %0d", $time, want.sample, env.sample);
        end
        if (env.segment !== want.segment) begin
          errors++;
          $display("%0t: segment expected %0d got %0d", $time, want.segment, env.segment);
        end
        if (env.holding !== want.holding) begin
          errors++;
          $display("%0t: holding expected %0d got %0d", $time, want.holding, env.holding);
        end
      end
    end
  end

  initial begin
    int phase_start;
    foreach (env_start[i]) begin
      env_start[i] = '0;
      env_level[i] = '0;
    end
    env_seg = 0;
    env_running = 1'b0;
    env_ticks = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    for (int i = 0; i < NUM_ROWS; i++) send_cmd(DIRECTED[i].c, DIRECTED[i].typed, DIRECTED[i].e);
    drain_envelopes();

    // Random phases, each under its own setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      sender_idles = !(ph == 2 || ph == 3);
      configure_phase(ph);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) run_sequence();
      drain_envelopes();
    end

    $display("Covered %0d command transactions and %0d envelope values over %0d settings.",
             items_sent, envs_seen, NUM_PHASES);
    if (errors == 0) begin
      $display("breakpoint_envelope_generator_top verification clean");
    end else begin
      $display("breakpoint_envelope_generator_top verification failed");
    end
    $finish;
  end

endmodule
